// ===== hdl/ezr_pkg.sv =====
// Package for the Z-Y-X Euler angle to rotation matrix unit.
// Holds fixed-point constants, the CORDIC arctangent table and shared types.
`timescale 1ns / 1ps
`default_nettype none
package ezr_pkg;

   localparam int CordicSteps = 16;
   localparam int AngleW = 19;
   localparam int ElemW = 18;
   localparam int ThrW = 17;
   localparam int CordW = 34;      // x, y in Q.30 with headroom
   localparam int ZW = 33;         // z in Q.30, signed

   localparam logic signed [AngleW-1:0] PiQ16 = 19'sd205887;
   localparam logic signed [AngleW-1:0] HalfPiQ16 = 19'sd102944;
   localparam logic signed [ZW-1:0] PiQ30 = 33'sd3373259426;
   localparam logic signed [ZW-1:0] HalfPiQ30 = 33'sd1686629713;
   localparam logic signed [CordW-1:0] GainQ30 = 34'sd652032874;
   localparam logic [ThrW-1:0] ThrReset = 17'd6554;

   localparam logic signed [ElemW-1:0] OneQ16 = 18'sd65536;

   function automatic logic signed [ZW-1:0] atan_q30(input int i);
      logic signed [ZW-1:0] r;
      unique case (i)
         0: r = 33'sd843314856;
         1: r = 33'sd497837829;
         2: r = 33'sd263043836;
         3: r = 33'sd133525158;
         4: r = 33'sd67021686;
         5: r = 33'sd33543515;
         6: r = 33'sd16775850;
         7: r = 33'sd8388437;
         8: r = 33'sd4194282;
         9: r = 33'sd2097149;
         10: r = 33'sd1048575;
         11: r = 33'sd524287;
         12: r = 33'sd262143;
         13: r = 33'sd131071;
         14: r = 33'sd65535;
         15: r = 33'sd32767;
         16: r = 33'sd16383;
         17: r = 33'sd8191;
         18: r = 33'sd4095;
         19: r = 33'sd2047;
         20: r = 33'sd1023;
         21: r = 33'sd511;
         22: r = 33'sd255;
         default: r = 33'sd127;
      endcase
      return r;
   endfunction

   // One CORDIC lane: rotation state of one angle
   typedef struct packed {
      logic signed [CordW-1:0] x;
      logic signed [CordW-1:0] y;
      logic signed [ZW-1:0] z;
      logic neg;
   } cordic_type;

endpackage
`default_nettype wire

// ===== hdl/euler_zyx_to_rotation_matrix_unit.sv =====
// Top level: Z-Y-X Euler angles to rotation matrix, fully pipelined.
// Depends on ezr_pkg and ezr_sincos.
//
// Takes one attitude per cycle unless the output is stalled, and answers
// with R = Rz(z)*Ry(y)*Rx(x) in Q1.16. Stages: angle clamp, CordicSteps + 1
// CORDIC stages, sine/cosine rounding, two multiplier stages, then sum and
// round into the output register; throughput is one item per clock. A
// result held by rsp_tready low freezes the whole pipeline, input included;
// bubbles ahead of it are not squeezed out. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module euler_zyx_to_rotation_matrix_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          csr_we,
   input  wire [16:0]   csr_wdata,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire [63:0]   req_tdata,   // angle_x, angle_y, angle_z (19 b each)
   input  wire          req_tuser,   // allow_singular
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [167:0] rsp_tdata,   // m00..m22 (18 b each)
   output logic         rsp_tuser    // near_singularity
);

   localparam int Lat = ezr_pkg::CordicSteps + 6;
   localparam int W = ezr_pkg::ElemW;

   logic [ezr_pkg::ThrW-1:0] thr_ff;
   logic [Lat-1:0] vld_ff, vld_in;
   logic en;

   // Pipeline advances unless the output is full and stalled
   assign en = !(vld_ff[Lat-1] && !rsp_tready);
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ezr_pkg::ThrReset;
         vld_ff <= '0;
      end else begin
         if (csr_we) thr_ff <= csr_wdata;
         if (en) vld_ff <= vld_in;
      end
   end
   assign vld_in = {vld_ff[Lat-2:0], req_tvalid};

   // Stage 0: clamp angles, singularity test
   logic signed [ezr_pkg::AngleW-1:0] ang_in [3], ang_ff [3];
   logic flag_in;
   logic [ezr_pkg::CordicSteps+4:0] flag_ff;
   always_comb begin
      logic signed [ezr_pkg::AngleW-1:0] a;
      logic signed [ezr_pkg::AngleW:0] d1, d2, dm;
      for (int k = 0; k < 3; k++) begin
         a = req_tdata[k*19 +: 19];
         if (a > ezr_pkg::PiQ16) ang_in[k] = ezr_pkg::PiQ16;
         else if (a < -ezr_pkg::PiQ16) ang_in[k] = -ezr_pkg::PiQ16;
         else ang_in[k] = a;
      end
      d1 = (ezr_pkg::AngleW+1)'(ang_in[1]) - (ezr_pkg::AngleW+1)'(ezr_pkg::HalfPiQ16);
      d2 = (ezr_pkg::AngleW+1)'(ang_in[1]) + (ezr_pkg::AngleW+1)'(ezr_pkg::HalfPiQ16);
      if (d1 < 0) d1 = -d1;
      if (d2 < 0) d2 = -d2;
      dm = (d1 < d2) ? d1 : d2;
      flag_in = !req_tuser && (dm < $signed({3'b000, thr_ff}));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) ang_ff[k] <= ang_in[k];
         flag_ff <= {flag_ff[ezr_pkg::CordicSteps+3:0], flag_in};
      end
   end

   // CORDIC lanes
   logic signed [W-1:0] sx, cx, sy, cy, sz, cz;
   ezr_sincos u_cx (.clock(clock), .en(en), .angle(ang_ff[0]), .sin_q16(sx), .cos_q16(cx));
   ezr_sincos u_cy (.clock(clock), .en(en), .angle(ang_ff[1]), .sin_q16(sy), .cos_q16(cy));
   ezr_sincos u_cz (.clock(clock), .en(en), .angle(ang_ff[2]), .sin_q16(sz), .cos_q16(cz));

   // Product stage 1: two-factor products (Q.32)
   logic signed [35:0] p1_ff [10];
   logic signed [W-1:0] cz1_ff, sz1_ff, sy1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff[0] <= cz * cy;  p1_ff[1] <= sy * sx;  p1_ff[2] <= sz * cx;
         p1_ff[3] <= sy * cx;  p1_ff[4] <= sz * sx;  p1_ff[5] <= sz * cy;
         p1_ff[6] <= cz * cx;  p1_ff[7] <= cz * sx;  p1_ff[8] <= cy * sx;
         p1_ff[9] <= cy * cx;
         cz1_ff <= cz; sz1_ff <= sz; sy1_ff <= sy;
      end
   end

   // Product stage 2: terms in Q.48
   logic signed [54:0] t_ff [13];
   always_ff @(posedge clock) begin
      if (en) begin
         t_ff[0]  <= 55'(p1_ff[0]) <<< 16;
         t_ff[1]  <= cz1_ff * p1_ff[1];
         t_ff[2]  <= 55'(p1_ff[2]) <<< 16;
         t_ff[3]  <= cz1_ff * p1_ff[3];
         t_ff[4]  <= 55'(p1_ff[4]) <<< 16;
         t_ff[5]  <= 55'(p1_ff[5]) <<< 16;
         t_ff[6]  <= sz1_ff * p1_ff[1];
         t_ff[7]  <= 55'(p1_ff[6]) <<< 16;
         t_ff[8]  <= sz1_ff * p1_ff[3];
         t_ff[9]  <= 55'(p1_ff[7]) <<< 16;
         t_ff[10] <= -(55'(sy1_ff) <<< 32);
         t_ff[11] <= 55'(p1_ff[8]) <<< 16;
         t_ff[12] <= 55'(p1_ff[9]) <<< 16;
      end
   end

   function automatic logic [W-1:0] rnd(input logic signed [54:0] v);
      logic signed [54:0] r;
      r = (v + 55'sd2147483648) >>> 32;
      if (r > 55'sd65536) return 18'sd65536;
      if (r < -55'sd65536) return -18'sd65536;
      return r[W-1:0];
   endfunction

   // Sum, round, saturate into the output register
   logic [167:0] out_ff;
   logic flag_out_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         out_ff[0*W +: W] <= rnd(t_ff[0]);
         out_ff[1*W +: W] <= rnd(t_ff[1] - t_ff[2]);
         out_ff[2*W +: W] <= rnd(t_ff[3] + t_ff[4]);
         out_ff[3*W +: W] <= rnd(t_ff[5]);
         out_ff[4*W +: W] <= rnd(t_ff[6] + t_ff[7]);
         out_ff[5*W +: W] <= rnd(t_ff[8] - t_ff[9]);
         out_ff[6*W +: W] <= rnd(t_ff[10]);
         out_ff[7*W +: W] <= rnd(t_ff[11]);
         out_ff[8*W +: W] <= rnd(t_ff[12]);
         out_ff[167:162] <= '0;
         flag_out_ff <= flag_ff[ezr_pkg::CordicSteps+4];
      end
   end

   assign rsp_tvalid = vld_ff[Lat-1];
   assign rsp_tdata = out_ff;
   assign rsp_tuser = flag_out_ff;

endmodule
`default_nettype wire

// ===== hdl/ezr_sincos.sv =====
// Pipelined CORDIC sine/cosine: one register stage per iteration.
// Depends on ezr_pkg. Stalls with en.
`timescale 1ns / 1ps
`default_nettype none
module ezr_sincos (
   input  wire                                      clock,
   input  wire                                      en,
   input  wire logic signed [ezr_pkg::AngleW-1:0]   angle,
   output logic signed [ezr_pkg::ElemW-1:0]         sin_q16,
   output logic signed [ezr_pkg::ElemW-1:0]         cos_q16
);

   ezr_pkg::cordic_type stage_ff [ezr_pkg::CordicSteps+1];
   ezr_pkg::cordic_type stage_in [ezr_pkg::CordicSteps+1];
   logic signed [ezr_pkg::ElemW-1:0] sin_ff, cos_ff, sin_in, cos_in;

   // Quadrant fold into [-pi/2, pi/2]
   always_comb begin
      logic signed [ezr_pkg::ZW-1:0] z;
      z = ezr_pkg::ZW'(angle) <<< 14;
      stage_in[0].x = ezr_pkg::GainQ30;
      stage_in[0].y = '0;
      stage_in[0].neg = 1'b0;
      stage_in[0].z = z;
      if (z > ezr_pkg::HalfPiQ30) begin
         stage_in[0].z = z - ezr_pkg::PiQ30;
         stage_in[0].neg = 1'b1;
      end else if (z < -ezr_pkg::HalfPiQ30) begin
         stage_in[0].z = z + ezr_pkg::PiQ30;
         stage_in[0].neg = 1'b1;
      end
   end

   // Micro-rotations, one per stage
   for (genvar i = 0; i < ezr_pkg::CordicSteps; i++) begin : g_step
      always_comb begin
         stage_in[i+1].neg = stage_ff[i].neg;
         if (!stage_ff[i].z[ezr_pkg::ZW-1]) begin
            stage_in[i+1].x = stage_ff[i].x - (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y + (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z - ezr_pkg::atan_q30(i);
         end else begin
            stage_in[i+1].x = stage_ff[i].x + (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y - (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z + ezr_pkg::atan_q30(i);
         end
      end
   end

   // Sign restore, round to Q.16 and saturate
   always_comb begin
      logic signed [ezr_pkg::CordW-1:0] x, y, rx, ry;
      x = stage_ff[ezr_pkg::CordicSteps].neg ? -stage_ff[ezr_pkg::CordicSteps].x
                                             : stage_ff[ezr_pkg::CordicSteps].x;
      y = stage_ff[ezr_pkg::CordicSteps].neg ? -stage_ff[ezr_pkg::CordicSteps].y
                                             : stage_ff[ezr_pkg::CordicSteps].y;
      rx = (x + ezr_pkg::CordW'(8192)) >>> 14;
      ry = (y + ezr_pkg::CordW'(8192)) >>> 14;
      if (rx > ezr_pkg::CordW'(ezr_pkg::OneQ16)) cos_in = ezr_pkg::OneQ16;
      else if (rx < -ezr_pkg::CordW'(ezr_pkg::OneQ16)) cos_in = -ezr_pkg::OneQ16;
      else cos_in = rx[ezr_pkg::ElemW-1:0];
      if (ry > ezr_pkg::CordW'(ezr_pkg::OneQ16)) sin_in = ezr_pkg::OneQ16;
      else if (ry < -ezr_pkg::CordW'(ezr_pkg::OneQ16)) sin_in = -ezr_pkg::OneQ16;
      else sin_in = ry[ezr_pkg::ElemW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= ezr_pkg::CordicSteps; k++) stage_ff[k] <= stage_in[k];
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_q16 = sin_ff;
   assign cos_q16 = cos_ff;

endmodule
`default_nettype wire

// ===== hdl/ezr_checker.sv =====
// Port-level checker for the rotation matrix unit, bound to the top level.
// Depends on nothing but the top-level ports.
`timescale 1ns / 1ps
`default_nettype none
module ezr_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [167:0] rsp_tdata
);
   // a held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
   // input side stalls only when the output is stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output stall");
   // no result right after reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result after reset");
   // pad bits stay zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[167:162] == 6'd0)
      else $error("pad bits set");
endmodule

bind euler_zyx_to_rotation_matrix_unit ezr_checker u_chk (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
`default_nettype wire
